/* design/cea_pkg.sv */
package cea_pkg;

  // Default sizes of the block dictionary and of the block counter.
  localparam int MAX_BLOCK_BITS_DEF   = 8;
  localparam int BLOCK_INDEX_BITS_DEF = 20;

  // Field widths of the channels and registers.
  localparam int BLOCK_LENGTH_W = 4;
  localparam int INIT_BLOCKS_W  = 21;
  localparam int LOG_W          = 21;
  localparam int SUM_W          = 41;
  localparam int SQ_SUM_W       = 61;
  localparam int COUNT_W        = 21;

  // Log2 arithmetic.
  localparam int FRAC_BITS  = 16;
  localparam int STEP_W     = 4;
  localparam int EXP_W      = 5;
  localparam int MANT_W     = 32;
  localparam int SQ_W       = 2 * LOG_W;
  // Widest block distance over the legal range of the counter size.
  localparam int DIST_MAX_W = 25;

  // Reset values of the configuration registers.
  localparam logic [BLOCK_LENGTH_W-1:0] BLOCK_LENGTH_RST = 4'd6;
  localparam logic [INIT_BLOCKS_W-1:0]  INIT_BLOCKS_RST  = 21'd1000;

  // Register indexes on the configuration port.
  localparam logic REG_BLOCK_LENGTH = 1'b0;
  localparam logic REG_INIT_BLOCKS  = 1'b1;

  // One job handed from the front to the back.
  typedef struct packed {
    logic                   clear;
    logic                   done;
    logic                   counted;
    logic                   overflow;
    logic [DIST_MAX_W-1:0]  distance;
    logic [COUNT_W-1:0]     test_count;
  } cea_job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_LOOKUP,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_NORM,
    B_LOG,
    B_SQUARE,
    B_ACC,
    B_OUT
  } back_state_t;

endpackage

/* design/cea_if.sv */
// Channel that carries noise bits into the block.
interface cea_noise_if;
  logic valid;
  logic ready;
  logic noise_bit;
  logic first_bit;
  logic last_bit;

  modport source (output valid, noise_bit, first_bit, last_bit, input ready);
  modport sink (input valid, noise_bit, first_bit, last_bit, output ready);
endinterface

// Channel that carries accumulated results out of the block.
interface cea_result_if;
  logic                        valid;
  logic                        ready;
  logic [cea_pkg::LOG_W-1:0]    log_distance;
  logic [cea_pkg::SUM_W-1:0]    distance_sum;
  logic [cea_pkg::SQ_SUM_W-1:0] distance_square_sum;
  logic [cea_pkg::COUNT_W-1:0]  test_block_count;
  logic                        block_counted;
  logic                        sequence_done;
  logic                        count_overflow;

  modport source (output valid, log_distance, distance_sum, distance_square_sum,
                  test_block_count, block_counted, sequence_done, count_overflow,
                  input ready);
  modport sink (input valid, log_distance, distance_sum, distance_square_sum,
                test_block_count, block_counted, sequence_done, count_overflow,
                output ready);
endinterface

/* design/cea_front.sv */
// Packs bits into blocks, keeps the dictionary and the block counter,
// and hands one job per relevant item to the queue.
module cea_front #(
  parameter int MAX_BLOCK_BITS   = cea_pkg::MAX_BLOCK_BITS_DEF,
  parameter int BLOCK_INDEX_BITS = cea_pkg::BLOCK_INDEX_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  cea_noise_if.sink                          noise,
  input  logic [cea_pkg::BLOCK_LENGTH_W-1:0] block_length,
  input  logic [cea_pkg::INIT_BLOCKS_W-1:0]  init_blocks,
  input  logic                               queue_full,
  output logic                               push,
  output cea_pkg::cea_job_t                  job
);

  localparam int DICT = 1 << MAX_BLOCK_BITS;
  localparam int IW   = MAX_BLOCK_BITS;
  localparam int PW   = $clog2(MAX_BLOCK_BITS + 1);
  localparam int BW   = BLOCK_INDEX_BITS + 1;
  localparam int CW   = (BW > cea_pkg::INIT_BLOCKS_W) ? BW : cea_pkg::INIT_BLOCKS_W;
  localparam int LW   = 5;

  cea_pkg::front_state_t state, state_next;

  logic [IW-1:0]   shift;
  logic [PW-1:0]   pos;
  logic [BW-1:0]   block_number;
  logic            overflow_flag;
  logic [DICT-1:0] seen_valid;
  logic [BW-1:0]   last_seen [DICT];
  logic [BW-1:0]   rd_data;
  logic [IW-1:0]   idx;
  logic            job_clear;
  logic            job_done;
  logic            job_counted;
  logic [BW-1:0]   job_dist;

  logic            accept;
  logic [LW-1:0]   len;
  logic [IW-1:0]   mask;
  logic [IW-1:0]   eff_shift;
  logic [PW-1:0]   eff_pos;
  logic [BW-1:0]   eff_bn;
  logic            eff_ovf;
  logic [IW-1:0]   sh_new;
  logic [LW-1:0]   pos_new;
  logic            complete;
  logic [BW-1:0]   lookup_dist;
  logic [CW-1:0]   bn_ext;
  logic [CW-1:0]   ib_ext;
  logic [CW-1:0]   tc;

  assign accept = noise.valid && noise.ready;

  // Clamp the block length into the legal range.
  always_comb begin
    if (block_length == '0) begin
      len = LW'(1);
    end else if (LW'(block_length) > LW'(MAX_BLOCK_BITS)) begin
      len = LW'(MAX_BLOCK_BITS);
    end else begin
      len = LW'(block_length);
    end
    for (int i = 0; i < IW; i++) begin
      mask[i] = (LW'(i) < len);
    end
  end

  // A new sequence starts from cleared state in the same item.
  always_comb begin
    eff_shift = noise.first_bit ? '0 : shift;
    eff_pos   = noise.first_bit ? '0 : pos;
    eff_bn    = noise.first_bit ? '0 : block_number;
    eff_ovf   = noise.first_bit ? 1'b0 : overflow_flag;
    sh_new    = (eff_shift << 1) | IW'(noise.noise_bit);
    pos_new   = LW'(eff_pos) + LW'(1);
    complete  = (pos_new >= len);
  end

  // Distance to the previous block of the same value, or the block number itself if the value is unseen.
  assign lookup_dist = block_number - (seen_valid[idx] ? rd_data : '0);

  // Test block count from the current block number.
  always_comb begin
    bn_ext = CW'(block_number);
    ib_ext = CW'(init_blocks);
    tc     = (bn_ext > ib_ext) ? (bn_ext - ib_ext) : '0;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      cea_pkg::F_IDLE: begin
        if (accept) begin
          priority if (complete && !eff_bn[BW-1]) begin
            state_next = cea_pkg::F_LOOKUP;
          end else if (noise.first_bit || noise.last_bit) begin
            state_next = cea_pkg::F_PUSH;
          end else begin
            state_next = cea_pkg::F_IDLE;
          end
        end
      end
      cea_pkg::F_LOOKUP: begin
        state_next = cea_pkg::F_PUSH;
      end
      cea_pkg::F_PUSH: begin
        if (!queue_full) begin
          state_next = cea_pkg::F_IDLE;
        end
      end
      default: begin
        state_next = cea_pkg::F_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    noise.ready    = (state == cea_pkg::F_IDLE);
    push           = (state == cea_pkg::F_PUSH) && !queue_full;
    job.clear      = job_clear;
    job.done       = job_done;
    job.counted    = job_counted;
    job.overflow   = overflow_flag;
    job.distance   = cea_pkg::DIST_MAX_W'(job_dist);
    job.test_count = cea_pkg::COUNT_W'(tc);
  end

  // Control state and block bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= cea_pkg::F_IDLE;
      shift         <= '0;
      pos           <= '0;
      block_number  <= '0;
      overflow_flag <= 1'b0;
      seen_valid    <= '0;
      job_clear     <= 1'b0;
      job_done      <= 1'b0;
      job_counted   <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (noise.first_bit) begin
          seen_valid <= '0;
        end
        shift         <= (complete || noise.last_bit) ? '0 : sh_new;
        pos           <= (complete || noise.last_bit) ? '0 : PW'(pos_new);
        overflow_flag <= eff_ovf | (complete & eff_bn[BW-1]);
        block_number  <= (complete && !eff_bn[BW-1]) ? eff_bn + BW'(1) : eff_bn;
        job_clear     <= noise.first_bit;
        job_done      <= noise.last_bit;
        job_counted   <= 1'b0;
      end
      if (state == cea_pkg::F_LOOKUP) begin
        seen_valid[idx] <= 1'b1;
        job_counted     <= (CW'(block_number) > CW'(init_blocks));
      end
    end
  end

  // Job payload.
  always_ff @(posedge clk) begin
    if (state == cea_pkg::F_LOOKUP) begin
      job_dist <= lookup_dist;
    end
  end

  // Dictionary memory: read on the accepting edge, written in the lookup cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      idx     <= sh_new & mask;
      rd_data <= last_seen[sh_new & mask];
    end
    if (state == cea_pkg::F_LOOKUP) begin
      last_seen[idx] <= block_number;
    end
  end

endmodule

/* design/cea_queue.sv */
// Two-entry job queue between the front and the back.
module cea_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  cea_pkg::cea_job_t push_job,
  input  logic              pop,
  output cea_pkg::cea_job_t pop_job,
  output logic              full,
  output logic              empty
);

  cea_pkg::cea_job_t entries [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign pop_job = entries[rptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_job;
    end
  end

endmodule

/* design/cea_back.sv */
// Takes jobs from the queue, forms the fixed point log2 of the distance,
// keeps the sums and holds the result register.
module cea_back #(
  parameter int BLOCK_INDEX_BITS = cea_pkg::BLOCK_INDEX_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              queue_empty,
  input  cea_pkg::cea_job_t job,
  output logic              pop,
  cea_result_if.source      result
);

  localparam int DW = BLOCK_INDEX_BITS + 1;
  localparam int MW = cea_pkg::MANT_W;

  cea_pkg::back_state_t state, state_next;

  logic                           cur_done;
  logic                           cur_counted;
  logic                           cur_overflow;
  logic [cea_pkg::COUNT_W-1:0]    cur_tc;
  logic [MW-1:0]                  mant;
  logic [cea_pkg::EXP_W-1:0]      expo;
  logic [cea_pkg::FRAC_BITS-1:0]  frac;
  logic [cea_pkg::STEP_W-1:0]     step;
  logic [cea_pkg::SQ_W-1:0]       sq;
  logic [cea_pkg::SUM_W-1:0]      log_sum;
  logic [cea_pkg::SQ_SUM_W-1:0]   log_square_sum;
  logic                           out_valid;

  logic [cea_pkg::LOG_W-1:0]      log_d;
  logic [2*MW-1:0]                prod;
  logic [MW:0]                    sq_top;
  logic                           load_out;

  assign log_d  = {expo, frac};
  assign prod   = (2*MW)'(mant) * (2*MW)'(mant);
  assign sq_top = prod[2*MW-1:MW-1];

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      cea_pkg::B_IDLE: begin
        if (!queue_empty) begin
          priority if (job.counted) begin
            state_next = cea_pkg::B_NORM;
          end else if (job.done) begin
            state_next = cea_pkg::B_OUT;
          end else begin
            state_next = cea_pkg::B_IDLE;
          end
        end
      end
      cea_pkg::B_NORM: begin
        if (mant[MW-1]) begin
          state_next = cea_pkg::B_LOG;
        end
      end
      cea_pkg::B_LOG: begin
        if (step == '1) begin
          state_next = cea_pkg::B_SQUARE;
        end
      end
      cea_pkg::B_SQUARE: begin
        state_next = cea_pkg::B_ACC;
      end
      cea_pkg::B_ACC: begin
        state_next = cea_pkg::B_OUT;
      end
      cea_pkg::B_OUT: begin
        if (!out_valid || result.ready) begin
          state_next = cea_pkg::B_IDLE;
        end
      end
      default: begin
        state_next = cea_pkg::B_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    pop          = (state == cea_pkg::B_IDLE) && !queue_empty;
    load_out     = (state == cea_pkg::B_OUT) && (!out_valid || result.ready);
    result.valid = out_valid;
  end

  // Control state and sums.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= cea_pkg::B_IDLE;
      out_valid      <= 1'b0;
      log_sum        <= '0;
      log_square_sum <= '0;
    end else begin
      state <= state_next;
      if (pop && job.clear) begin
        log_sum        <= '0;
        log_square_sum <= '0;
      end
      if (state == cea_pkg::B_ACC) begin
        log_sum        <= log_sum + cea_pkg::SUM_W'(log_d);
        log_square_sum <= log_square_sum + cea_pkg::SQ_SUM_W'(sq);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Log2 datapath: normalize one bit a cycle, then one squaring per fraction bit.
  always_ff @(posedge clk) begin
    unique case (state)
      cea_pkg::B_IDLE: begin
        if (pop) begin
          cur_done     <= job.done;
          cur_counted  <= job.counted;
          cur_overflow <= job.overflow;
          cur_tc       <= job.test_count;
          mant         <= MW'(job.distance[DW-1:0]) << (MW - DW);
          expo         <= cea_pkg::EXP_W'(DW - 1);
          frac         <= '0;
          step         <= '0;
        end
      end
      cea_pkg::B_NORM: begin
        if (!mant[MW-1]) begin
          mant <= mant << 1;
          expo <= expo - cea_pkg::EXP_W'(1);
        end
      end
      cea_pkg::B_LOG: begin
        frac <= {frac[cea_pkg::FRAC_BITS-2:0], sq_top[MW]};
        mant <= sq_top[MW] ? sq_top[MW:1] : sq_top[MW-1:0];
        step <= step + cea_pkg::STEP_W'(1);
      end
      cea_pkg::B_SQUARE: begin
        sq <= cea_pkg::SQ_W'(log_d) * cea_pkg::SQ_W'(log_d);
      end
      default: begin
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (load_out) begin
      result.log_distance        <= cur_counted ? log_d : '0;
      result.distance_sum        <= log_sum;
      result.distance_square_sum <= log_square_sum;
      result.test_block_count    <= cur_tc;
      result.block_counted       <= cur_counted;
      result.sequence_done       <= cur_done;
      result.count_overflow      <= cur_overflow;
    end
  end

endmodule

/* design/compression_estimate_accumulator.sv */
// A bit that completes a test block passes the front's lookup and push states, the queue
// and the back end's normalize, log2, square, accumulate and output states before its
// result is presented. The front takes one bit a cycle when no block completes and no
// first or last bit comes; such a bit holds the front in its lookup or push state, and a
// counted block the back end in its log2 unit; the two-entry queue absorbs short bursts.
// Reset (synchronous, active high) clears valid bits, counters, sums and queue.
module compression_estimate_accumulator #(
  parameter int MAX_BLOCK_BITS   = cea_pkg::MAX_BLOCK_BITS_DEF,
  parameter int BLOCK_INDEX_BITS = cea_pkg::BLOCK_INDEX_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  cea_noise_if.sink   noise,
  cea_result_if.source result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [cea_pkg::BLOCK_LENGTH_W-1:0] block_length;
  logic [cea_pkg::INIT_BLOCKS_W-1:0]  init_blocks;
  logic                               cfg_write;
  logic                               push;
  logic                               pop;
  logic                               queue_full;
  logic                               queue_empty;
  cea_pkg::cea_job_t                  push_job;
  cea_pkg::cea_job_t                  pop_job;

  // Configuration registers.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_length <= cea_pkg::BLOCK_LENGTH_RST;
      init_blocks  <= cea_pkg::INIT_BLOCKS_RST;
    end else if (cfg_write) begin
      unique case (paddr[2])
        cea_pkg::REG_BLOCK_LENGTH: block_length <= pwdata[cea_pkg::BLOCK_LENGTH_W-1:0];
        cea_pkg::REG_INIT_BLOCKS:  init_blocks  <= pwdata[cea_pkg::INIT_BLOCKS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register read back.
  always_comb begin
    unique case (paddr[2])
      cea_pkg::REG_BLOCK_LENGTH: prdata = 32'(block_length);
      cea_pkg::REG_INIT_BLOCKS:  prdata = 32'(init_blocks);
      default:                   prdata = '0;
    endcase
  end

  cea_front #(
    .MAX_BLOCK_BITS   (MAX_BLOCK_BITS),
    .BLOCK_INDEX_BITS (BLOCK_INDEX_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .noise        (noise),
    .block_length (block_length),
    .init_blocks  (init_blocks),
    .queue_full   (queue_full),
    .push         (push),
    .job          (push_job)
  );

  cea_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .full     (queue_full),
    .empty    (queue_empty)
  );

  cea_back #(
    .BLOCK_INDEX_BITS (BLOCK_INDEX_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .job         (pop_job),
    .pop         (pop),
    .result      (result)
  );

endmodule
